[src/dcfir_pkg.sv]
// Shared types, constants and the tap table of the dual-channel low-pass FIR.
// Used by the channel interfaces, the delay line, the MAC lane and the top level.
`default_nettype none

package dcfir_pkg;

   localparam int TAP_COUNT     = 51;
   localparam int SAMPLE_WIDTH  = 16;
   localparam int TAP_WIDTH     = 12;
   localparam int TAP_IDX_WIDTH = $clog2(TAP_COUNT);
   localparam int PROD_WIDTH    = SAMPLE_WIDTH + TAP_WIDTH;
   localparam int ACC_WIDTH     = 40;
   localparam int COEF_SHIFT    = 15;
   localparam int QUOT_WIDTH    = ACC_WIDTH - COEF_SHIFT;

   localparam logic [TAP_IDX_WIDTH-1:0] LAST_TAP = TAP_IDX_WIDTH'(TAP_COUNT - 1);
   localparam logic signed [ACC_WIDTH-1:0] ROUND_BIAS = ACC_WIDTH'(2 ** (COEF_SHIFT - 1));
   localparam logic signed [QUOT_WIDTH-1:0] QUOT_MAX =
      QUOT_WIDTH'((2 ** (SAMPLE_WIDTH - 1)) - 1);
   localparam logic signed [QUOT_WIDTH-1:0] QUOT_MIN =
      -QUOT_WIDTH'(2 ** (SAMPLE_WIDTH - 1));

   typedef logic signed [SAMPLE_WIDTH-1:0] sample_type;
   typedef logic signed [TAP_WIDTH-1:0]    tap_type;
   typedef logic signed [PROD_WIDTH-1:0]   prod_type;
   typedef logic signed [ACC_WIDTH-1:0]    acc_type;
   typedef logic [TAP_IDX_WIDTH-1:0]       tap_idx_type;

   // Sequencer controls shared by both lanes.
   typedef struct packed {
      logic        load;     // new item enters the delay line, accumulator clears
      logic        mul_en;   // multiply the head word, rotate the delay line
      logic        acc_en;   // add the registered product into the accumulator
      tap_idx_type tap;      // tap index of the current multiply
   } mac_ctrl_type;

   // Symmetric Q1.15 low-pass taps.
   localparam tap_type TAP_TABLE [TAP_COUNT] = '{
      12'sd0,    12'sd5,    12'sd13,   12'sd23,   12'sd39,
      12'sd61,   12'sd91,   12'sd131,  12'sd180,  12'sd240,
      12'sd312,  12'sd393,  12'sd485,  12'sd585,  12'sd691,
      12'sd801,  12'sd914,  12'sd1025, 12'sd1133, 12'sd1234,
      12'sd1325, 12'sd1403, 12'sd1467, 12'sd1514, 12'sd1543,
      12'sd1552, 12'sd1543, 12'sd1514, 12'sd1467, 12'sd1403,
      12'sd1325, 12'sd1234, 12'sd1133, 12'sd1025, 12'sd914,
      12'sd801,  12'sd691,  12'sd585,  12'sd485,  12'sd393,
      12'sd312,  12'sd240,  12'sd180,  12'sd131,  12'sd91,
      12'sd61,   12'sd39,   12'sd23,   12'sd13,   12'sd5,
      12'sd0
   };

   function automatic tap_type tap_coef(input tap_idx_type idx);
      tap_type coef;
      coef = '0;
      if (idx <= LAST_TAP) begin
         coef = TAP_TABLE[idx];
      end
      return coef;
   endfunction

endpackage

`default_nettype wire

[src/dcfir_if.sv]
// Valid/ready channel interfaces for the sample items and the filtered items.
// Depends on dcfir_pkg for the sample type.
`default_nettype none

interface dcfir_req_if;
   logic                 valid;
   logic                 ready;
   dcfir_pkg::sample_type sample_red;
   dcfir_pkg::sample_type sample_infrared;

   modport source (output valid, output sample_red, output sample_infrared, input ready);
   modport sink   (input valid, input sample_red, input sample_infrared, output ready);
endinterface

interface dcfir_rsp_if;
   logic                 valid;
   logic                 ready;
   dcfir_pkg::sample_type filtered_red;
   dcfir_pkg::sample_type filtered_infrared;

   modport source (output valid, output filtered_red, output filtered_infrared, input ready);
   modport sink   (input valid, input filtered_red, input filtered_infrared, output ready);
endinterface

`default_nettype wire

[src/dual_channel_fir_lowpass_top.sv]
// Dual-channel 51-tap low-pass FIR filter, top level with the tap sequencer.
// Depends on dcfir_pkg, dcfir_if, dcfir_delay_line and dcfir_mac.
//
// Each item on req_chan carries one red and one infrared 16-bit signed sample; each
// item on rsp_chan carries the two filtered samples, in the same order, one result
// per input item. Both channels use the same symmetric Q1.15 low-pass taps. The
// exact sum of tap times sample is rounded to nearest (ties toward plus infinity)
// and saturated to 16 bits. After reset the sample history is all zero, so the
// first outputs use only the samples received so far. The sample shifts into the
// delay line at the accepting edge itself. From there each lane's single multiplier
// walks the taps while the delay line rotates one word per cycle; then the last
// product is added, and the rounded sum moves into the output register, from which
// the sink can take it. The next item is accepted as soon as the result sits in
// the output register, even if the sink has not taken it yet; a new result waits
// only if the previous one is still held.
`default_nettype none

module dual_channel_fir_lowpass_top (
   input wire logic  clock,
   input wire logic  reset,
   dcfir_req_if.sink   req_chan,
   dcfir_rsp_if.source rsp_chan
);

   localparam logic [1:0] ST_IDLE  = 2'd0;
   localparam logic [1:0] ST_MAC   = 2'd1;
   localparam logic [1:0] ST_DRAIN = 2'd2;
   localparam logic [1:0] ST_DONE  = 2'd3;

   logic [1:0]               state_ff;
   logic [1:0]               state_in;
   dcfir_pkg::tap_idx_type   step_ff;
   dcfir_pkg::tap_idx_type   step_in;
   logic                     rsp_valid_ff;
   logic                     rsp_valid_in;
   dcfir_pkg::sample_type    red_out_ff;
   dcfir_pkg::sample_type    infrared_out_ff;

   dcfir_pkg::mac_ctrl_type  ctrl;
   dcfir_pkg::sample_type    red_head;
   dcfir_pkg::sample_type    infrared_head;
   dcfir_pkg::sample_type    red_filtered;
   dcfir_pkg::sample_type    infrared_filtered;

   logic accept;
   logic load_out;

   // Input side is open whenever no item is in flight.
   assign req_chan.ready = (state_ff == ST_IDLE);
   assign accept         = req_chan.valid && req_chan.ready;

   // The result moves to the output register once the previous one has left.
   assign load_out = (state_ff == ST_DONE) && (!rsp_valid_ff || rsp_chan.ready);

   // Products are registered, so each product is accumulated in the cycle after its multiply.
   always_comb begin
      ctrl.load   = accept;
      ctrl.mul_en = (state_ff == ST_MAC);
      ctrl.acc_en = ((state_ff == ST_MAC) && (step_ff != '0)) || (state_ff == ST_DRAIN);
      ctrl.tap    = step_ff;
   end

   always_comb begin
      state_in = state_ff;
      step_in  = step_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               state_in = ST_MAC;
               step_in  = '0;
            end
         end
         ST_MAC: begin
            step_in = step_ff + 1'b1;
            if (step_ff == dcfir_pkg::LAST_TAP) begin
               state_in = ST_DRAIN;
               step_in  = '0;
            end
         end
         ST_DRAIN: begin
            state_in = ST_DONE;
         end
         ST_DONE: begin
            if (load_out) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
            step_in  = '0;
         end
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (load_out) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_chan.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         step_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         step_ff      <= step_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load_out) begin
         red_out_ff      <= red_filtered;
         infrared_out_ff <= infrared_filtered;
      end
   end

   assign rsp_chan.valid             = rsp_valid_ff;
   assign rsp_chan.filtered_red      = red_out_ff;
   assign rsp_chan.filtered_infrared = infrared_out_ff;

   dcfir_delay_line u_red_line (
      .clock  (clock),
      .reset  (reset),
      .ctrl   (ctrl),
      .sample (req_chan.sample_red),
      .head   (red_head)
   );

   dcfir_delay_line u_infrared_line (
      .clock  (clock),
      .reset  (reset),
      .ctrl   (ctrl),
      .sample (req_chan.sample_infrared),
      .head   (infrared_head)
   );

   dcfir_mac u_red_mac (
      .clock    (clock),
      .ctrl     (ctrl),
      .head     (red_head),
      .filtered (red_filtered)
   );

   dcfir_mac u_infrared_mac (
      .clock    (clock),
      .ctrl     (ctrl),
      .head     (infrared_head),
      .filtered (infrared_filtered)
   );

   // An accepted item always starts its tap walk at the first tap.
   assert property (@(posedge clock) disable iff (reset)
      accept |=> (state_ff == ST_MAC) && (step_ff == '0))
      else $error("tap walk did not start at the first tap");

   // The tap index never runs past the last tap.
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_MAC) |-> (step_ff <= dcfir_pkg::LAST_TAP))
      else $error("tap index out of range");

   // The final accumulate follows the multiply of the last tap.
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DRAIN) |-> $past(state_ff == ST_MAC && step_ff == dcfir_pkg::LAST_TAP))
      else $error("drain entered before all taps were multiplied");

   // A new result shows up only out of the finishing state.
   assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> ($past(state_ff) == ST_DONE))
      else $error("result presented without a finished item");

   // No item is accepted while one is still being filtered.
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_MAC || state_ff == ST_DRAIN) |-> !ctrl.load)
      else $error("delay line loaded during a tap walk");

endmodule

`default_nettype wire

[src/dcfir_delay_line.sv]
// Rotating sample delay line of one channel: shifts in a new item, then rotates
// once per multiply so the head word walks all taps. Depends on dcfir_pkg.
`default_nettype none

module dcfir_delay_line (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire dcfir_pkg::mac_ctrl_type ctrl,
   input  wire dcfir_pkg::sample_type   sample,
   output      dcfir_pkg::sample_type   head
);

   dcfir_pkg::sample_type line_ff [dcfir_pkg::TAP_COUNT];
   dcfir_pkg::sample_type line_in [dcfir_pkg::TAP_COUNT];

   // A full pass of TAP_COUNT rotations restores the original order.
   always_comb begin
      line_in = line_ff;
      if (ctrl.load) begin
         line_in[0] = sample;
         for (int i = 1; i < dcfir_pkg::TAP_COUNT; i++) begin
            line_in[i] = line_ff[i-1];
         end
      end else if (ctrl.mul_en) begin
         for (int i = 0; i < dcfir_pkg::TAP_COUNT - 1; i++) begin
            line_in[i] = line_ff[i+1];
         end
         line_in[dcfir_pkg::TAP_COUNT-1] = line_ff[0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < dcfir_pkg::TAP_COUNT; i++) begin
            line_ff[i] <= '0;
         end
      end else begin
         line_ff <= line_in;
      end
   end

   assign head = line_ff[0];

endmodule

`default_nettype wire

[src/dcfir_mac.sv]
// Multiply-accumulate lane of one channel, with round-to-nearest and saturation
// of the accumulated sum. Depends on dcfir_pkg for the tap table and widths.
`default_nettype none

module dcfir_mac (
   input  wire logic                    clock,
   input  wire dcfir_pkg::mac_ctrl_type ctrl,
   input  wire dcfir_pkg::sample_type   head,
   output      dcfir_pkg::sample_type   filtered
);

   dcfir_pkg::tap_type  coef;
   dcfir_pkg::prod_type product_ff;
   dcfir_pkg::prod_type product_in;
   dcfir_pkg::acc_type  acc_ff;
   dcfir_pkg::acc_type  acc_in;
   dcfir_pkg::acc_type  biased;
   logic signed [dcfir_pkg::QUOT_WIDTH-1:0] quot;

   assign coef       = dcfir_pkg::tap_coef(ctrl.tap);
   assign product_in = dcfir_pkg::PROD_WIDTH'(head) * dcfir_pkg::PROD_WIDTH'(coef);

   always_comb begin
      acc_in = acc_ff;
      if (ctrl.load) begin
         acc_in = '0;
      end else if (ctrl.acc_en) begin
         acc_in = acc_ff + dcfir_pkg::ACC_WIDTH'(product_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (ctrl.mul_en) begin
         product_ff <= product_in;
      end
      acc_ff <= acc_in;
   end

   // Ties round toward plus infinity; the floor comes from the arithmetic select.
   assign biased = acc_ff + dcfir_pkg::ROUND_BIAS;
   assign quot   = $signed(biased[dcfir_pkg::ACC_WIDTH-1:dcfir_pkg::COEF_SHIFT]);

   always_comb begin
      if (quot > dcfir_pkg::QUOT_MAX) begin
         filtered = dcfir_pkg::SAMPLE_WIDTH'(dcfir_pkg::QUOT_MAX);
      end else if (quot < dcfir_pkg::QUOT_MIN) begin
         filtered = dcfir_pkg::SAMPLE_WIDTH'(dcfir_pkg::QUOT_MIN);
      end else begin
         filtered = quot[dcfir_pkg::SAMPLE_WIDTH-1:0];
      end
   end

endmodule

`default_nettype wire

[sim/tb.sv]
// Self-checking testbench of the dual-channel low-pass FIR: a short directed table,
// then random sample streams, each result compared with a typed value or a bit-exact filter model.
// Depends on dcfir_pkg, dcfir_if and dual_channel_fir_lowpass_top.
`default_nettype none

module tb;

   typedef dcfir_pkg::sample_type sample_type;

   // Filter geometry and output range, kept apart from the design's own copies.
   localparam int     TAP_TOTAL     = 51;
   localparam int     HISTORY_DEPTH = TAP_TOTAL - 1;
   localparam int     FRAC_BITS     = 15;
   localparam longint OUT_MAX       = 32767;
   localparam longint OUT_MIN       = -32768;

   // Run shape. The watchdog limit covers the longest sender gap, one full pass of
   // the tap walk and a long run of receiver stalls.
   localparam int ITEMS_PER_PHASE = 300;
   localparam int PHASE_COUNT     = 3;
   localparam int QUIET_LIMIT     = 2000;
   localparam int DRAIN_CYCLES    = 60;

   // Per-phase idle rates in percent: sender, then receiver.
   localparam int SEND_IDLE_PCT [PHASE_COUNT]  = '{31, 45, 0};
   localparam int RECV_STALL_PCT [PHASE_COUNT] = '{45, 31, 0};

   // Symmetric Q1.15 low-pass taps. Their sum is exactly 32768, so the DC gain is one.
   localparam int LOWPASS_TAPS [TAP_TOTAL] = '{
      0,    5,    13,   23,   39,   61,   91,   131,  180,  240,
      312,  393,  485,  585,  691,  801,  914,  1025, 1133, 1234,
      1325, 1403, 1467, 1514, 1543, 1552, 1543, 1514, 1467, 1403,
      1325, 1234, 1133, 1025, 914,  801,  691,  585,  485,  393,
      312,  240,  180,  131,  91,   61,   39,   23,   13,   5,
      0
   };

   typedef struct packed {
      sample_type red;
      sample_type infrared;
   } sample_pair_type;

   typedef struct packed {
      sample_pair_type stim;
      logic            has_want;
      sample_pair_type want;
   } table_row_type;

   // Shapes of the random sample streams.
   typedef enum int {
      WAVE_WIDE,
      WAVE_SMALL,
      WAVE_HOLD,
      WAVE_ALTERNATE,
      WAVE_IMPULSE
   } wave_kind_type;

   localparam sample_type FULL_POS = 16'sh7FFF;
   localparam sample_type FULL_NEG = 16'sh8000;

   // Directed rows. Only the first two carry a typed expectation: right after reset
   // the first output is always zero because the first tap is zero, and the second
   // output is the second tap (5) times the first sample, here exactly +2.5 and -2.5,
   // which round toward plus infinity to 3 and -2. All other rows use the model.
   localparam int DIRECTED_COUNT = 14;
   localparam table_row_type DIRECTED_ROWS [DIRECTED_COUNT] = '{
      '{'{16'sd16384, -16'sd16384}, 1'b1, '{16'sd0, 16'sd0}},
      '{'{16'sd0, 16'sd0},          1'b1, '{16'sd3, -16'sd2}},
      '{'{FULL_POS, FULL_NEG},      1'b0, '{16'sd0, 16'sd0}},
      '{'{FULL_NEG, FULL_POS},      1'b0, '{16'sd0, 16'sd0}},
      '{'{FULL_POS, FULL_POS},      1'b0, '{16'sd0, 16'sd0}},
      '{'{FULL_NEG, FULL_NEG},      1'b0, '{16'sd0, 16'sd0}},
      '{'{16'sd0, 16'sd0},          1'b0, '{16'sd0, 16'sd0}},
      '{'{-16'sd1, 16'sd1},         1'b0, '{16'sd0, 16'sd0}},
      '{'{16'sd1, -16'sd1},         1'b0, '{16'sd0, 16'sd0}},
      '{'{16'sh5555, 16'shAAAA},    1'b0, '{16'sd0, 16'sd0}},
      '{'{16'shAAAA, 16'sh5555},    1'b0, '{16'sd0, 16'sd0}},
      '{'{16'sh7FFF, 16'sh8000},    1'b0, '{16'sd0, 16'sd0}},
      '{'{16'sh0001, 16'sh8001},    1'b0, '{16'sd0, 16'sd0}},
      '{'{16'sh4000, -16'sh4000},   1'b0, '{16'sd0, 16'sd0}}
   };

   logic clock;
   logic reset;

   dcfir_req_if req_chan ();
   dcfir_rsp_if rsp_chan ();

   dual_channel_fir_lowpass_top i_dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan)
   );

   // The typed expectation travels with the item, so the monitor can pick it up at
   // the edge where the item is accepted.
   logic            item_has_want;
   sample_pair_type item_want;

   // Filter model state: the last 50 samples of each channel and the next write slot.
   sample_type red_past [HISTORY_DEPTH];
   sample_type ir_past [HISTORY_DEPTH];
   int         past_slot;

   // Filtered pairs that the design still owes, oldest first.
   sample_pair_type filtered_due [$];

   int error_count;
   int quiet_cycles;
   int send_idle_pct;
   int recv_stall_pct;

   // State of the random stream generator.
   wave_kind_type   run_kind;
   int              run_left;
   int              run_index;
   sample_pair_type hold_pair;

   initial clock = 1'b0;
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   task automatic report_mismatch(input string msg);
      $display("MISMATCH at %0t: %s", $time, msg);
      error_count++;
   endtask

   // Exact tap sum over the new sample and the stored history, then round to
   // nearest with ties toward plus infinity and clamp to the 16-bit range.
   function automatic sample_type lowpass_channel(input sample_type x,
                                                   input sample_type past [HISTORY_DEPTH]);
      longint acc;
      longint rounded;
      int     k;
      acc = longint'(LOWPASS_TAPS[0]) * longint'(x);
      for (k = 1; k < TAP_TOTAL; k++) begin
         acc += longint'(LOWPASS_TAPS[k]) *
                longint'(past[(past_slot + HISTORY_DEPTH - k) % HISTORY_DEPTH]);
      end
      rounded = (acc + (64'sd1 <<< (FRAC_BITS - 1))) >>> FRAC_BITS;
      if (rounded > OUT_MAX) begin
         rounded = OUT_MAX;
      end
      if (rounded < OUT_MIN) begin
         rounded = OUT_MIN;
      end
      return sample_type'(rounded);
   endfunction

   // Filters one accepted pair and then shifts it into the history rings.
   task automatic lowpass_advance(input sample_pair_type stim,
                                  output sample_pair_type filtered);
      filtered.red      = lowpass_channel(stim.red, red_past);
      filtered.infrared = lowpass_channel(stim.infrared, ir_past);
      red_past[past_slot] = stim.red;
      ir_past[past_slot]  = stim.infrared;
      past_slot = (past_slot + 1) % HISTORY_DEPTH;
   endtask

   function automatic sample_type pick_level();
      sample_type level;
      case ($urandom_range(2))
         0: level = FULL_POS;
         1: level = FULL_NEG;
         default: level = sample_type'($urandom);
      endcase
      return level;
   endfunction

   // Random streams come in runs of one shape. Held full-scale runs drive the
   // output to the very edge of its range, alternating runs give the largest
   // swings, impulses expose single taps, and wide runs toggle every input bit.
   task automatic next_sample_pair(output sample_pair_type pair);
      if (run_left == 0) begin
         run_kind  = wave_kind_type'($urandom_range(WAVE_IMPULSE));
         run_left  = $urandom_range(60, 1);
         run_index = 0;
         hold_pair.red      = pick_level();
         hold_pair.infrared = pick_level();
      end
      case (run_kind)
         WAVE_WIDE: begin
            pair.red      = sample_type'($urandom);
            pair.infrared = sample_type'($urandom);
         end
         WAVE_SMALL: begin
            pair.red      = sample_type'(int'($urandom_range(512)) - 256);
            pair.infrared = sample_type'(int'($urandom_range(512)) - 256);
         end
         WAVE_HOLD: begin
            pair = hold_pair;
         end
         WAVE_ALTERNATE: begin
            pair.red      = run_index[0] ? FULL_NEG : FULL_POS;
            pair.infrared = run_index[0] ? FULL_POS : FULL_NEG;
         end
         default: begin
            pair = (run_index == 0) ? hold_pair : '0;
         end
      endcase
      run_index++;
      run_left--;
   endtask

   // Offers one item from a falling edge, idling first at the current rate, and
   // returns at the falling edge after the item has been accepted. Now and then an
   // idle stretch is long enough to fall in the middle of the tap walk.
   task automatic send_item(input sample_pair_type stim, input logic has_want,
                            input sample_pair_type want);
      int gap;
      while ($urandom_range(99) < send_idle_pct) begin
         gap = ($urandom_range(7) == 0) ? int'($urandom_range(60, 1)) : 1;
         req_chan.valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_chan.valid           <= 1'b1;
      req_chan.sample_red      <= stim.red;
      req_chan.sample_infrared <= stim.infrared;
      item_has_want            <= has_want;
      item_want                <= want;
      do begin
         @(posedge clock);
      end while (req_chan.ready !== 1'b1);
      @(negedge clock);
   endtask

   // The receiver decides at every falling edge whether it takes a result.
   always @(negedge clock) begin
      rsp_chan.ready <= ($urandom_range(99) >= recv_stall_pct);
   end

   // Monitor: at each rising edge a taken result is checked first and an accepted
   // item is predicted second, so the queue always holds the oldest item in front.
   always @(posedge clock) begin
      sample_pair_type seen;
      sample_pair_type stim;
      sample_pair_type want;
      if (!reset) begin
         if (rsp_chan.valid === 1'b1 && rsp_chan.ready === 1'b1) begin
            seen.red      = rsp_chan.filtered_red;
            seen.infrared = rsp_chan.filtered_infrared;
            if (filtered_due.size() == 0) begin
               report_mismatch($sformatf("result %0d/%0d arrived with none due",
                                         seen.red, seen.infrared));
            end else begin
               want = filtered_due.pop_front();
               if (seen.red !== want.red) begin
                  report_mismatch($sformatf("filtered_red got %0d, expected %0d",
                                            seen.red, want.red));
               end
               if (seen.infrared !== want.infrared) begin
                  report_mismatch($sformatf("filtered_infrared got %0d, expected %0d",
                                            seen.infrared, want.infrared));
               end
            end
         end
         if (req_chan.valid === 1'b1 && req_chan.ready === 1'b1) begin
            stim.red      = req_chan.sample_red;
            stim.infrared = req_chan.sample_infrared;
            lowpass_advance(stim, want);
            if (item_has_want) begin
               want = item_want;
            end
            filtered_due.push_back(want);
         end
      end
   end

   // Watchdog: too many cycles in a row without any item moving ends the run.
   always @(posedge clock) begin
      if (reset || (req_chan.valid && req_chan.ready) || (rsp_chan.valid && rsp_chan.ready))
      begin
         quiet_cycles = 0;
      end else begin
         quiet_cycles++;
      end
      if (quiet_cycles >= QUIET_LIMIT) begin
         $display("Timeout: no item moved for %0d cycles", QUIET_LIMIT);
         $display("== FAIL ==");
         $finish;
      end
   end

   initial begin
      sample_pair_type pair;
      int              n;
      int              phase;

      reset                    = 1'b1;
      req_chan.valid           = 1'b0;
      req_chan.sample_red      = '0;
      req_chan.sample_infrared = '0;
      rsp_chan.ready           = 1'b0;
      item_has_want            = 1'b0;
      item_want                = '0;
      error_count              = 0;
      quiet_cycles             = 0;
      run_left                 = 0;
      run_index                = 0;
      run_kind                 = WAVE_WIDE;
      hold_pair                = '0;
      past_slot                = 0;
      for (n = 0; n < HISTORY_DEPTH; n++) begin
         red_past[n] = '0;
         ir_past[n]  = '0;
      end
      send_idle_pct  = SEND_IDLE_PCT[0];
      recv_stall_pct = RECV_STALL_PCT[0];

      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed part: start-up, the rounding tie and the full-scale corners.
      for (n = 0; n < DIRECTED_COUNT; n++) begin
         send_item(DIRECTED_ROWS[n].stim, DIRECTED_ROWS[n].has_want, DIRECTED_ROWS[n].want);
      end

      // Random part, one phase per idling pattern; the last phase runs flat out.
      for (phase = 0; phase < PHASE_COUNT; phase++) begin
         send_idle_pct  = SEND_IDLE_PCT[phase];
         recv_stall_pct = RECV_STALL_PCT[phase];
         for (n = 0; n < ITEMS_PER_PHASE; n++) begin
            next_sample_pair(pair);
            send_item(pair, 1'b0, '0);
         end
      end
      req_chan.valid <= 1'b0;

      // Wait for every owed result, then a little longer to catch a stray one.
      while (filtered_due.size() != 0) begin
         @(posedge clock);
      end
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (error_count == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

endmodule

`default_nettype wire
